[src/pccx_pkg.sv]
// ----------------------------------------------------------------------------
// Cycle crossover package
// Shared widths, status codes and the request record that travels from the
// front end through the request queue to the crossover engine.
// ----------------------------------------------------------------------------
package pccx_pkg;

  localparam int GENE_W         = 6;
  localparam int STORE_DEPTH    = 64;
  localparam int COUNT_W        = 7;
  localparam int CITY_LIMIT_DEF = 64;
  localparam int QUEUE_DEPTH    = 4;

  typedef logic [GENE_W-1:0]      gene_t;
  typedef logic [COUNT_W-1:0]     count_t;
  typedef logic [STORE_DEPTH-1:0] mark_vec_t;
  typedef logic [1:0]             status_t;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_OVERFLOW = 2'd1;
  localparam status_t ST_MISMATCH = 2'd2;

  typedef struct packed {
    gene_t first_gene;
    gene_t second_gene;
    gene_t head;
    gene_t pos;
    logic  first_item;
    logic  drop;
    logic  last_item;
  } req_t;

endpackage

[src/pccx_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pccx_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/pccx_front.sv]
// ----------------------------------------------------------------------------
// Cycle crossover front end
// Accepts gene pairs, numbers their positions, marks the first request of a
// set and flags requests beyond the city limit, then pushes them to the queue.
// ----------------------------------------------------------------------------
module pccx_front import pccx_pkg::*; #(
  parameter int CITY_LIMIT = CITY_LIMIT_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  gene_t in_first_parent_gene,
  input  gene_t in_second_parent_gene,
  input  gene_t in_head_city,
  input  logic  in_last_item,
  input  logic  q_full,
  output logic  q_push,
  output req_t  q_req
);

  count_t count_r;
  count_t count_nxt;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_req.first_gene  = in_first_parent_gene;
    q_req.second_gene = in_second_parent_gene;
    q_req.head        = in_head_city;
    q_req.pos         = count_r[GENE_W-1:0];
    q_req.first_item  = (count_r == '0);
    q_req.drop        = (count_r >= COUNT_W'(CITY_LIMIT));
    q_req.last_item   = in_last_item;
    count_nxt = count_r;
    if (q_push) begin
      if (in_last_item) begin
        count_nxt = '0;
      end else if (!q_req.drop) begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

[src/pccx_queue.sv]
// ----------------------------------------------------------------------------
// Request queue
// A short first-in first-out queue that decouples the front end from the
// crossover engine.
// ----------------------------------------------------------------------------
module pccx_queue import pccx_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  req_t push_req,
  output logic full,
  output logic valid,
  input  logic pop,
  output req_t pop_req
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  req_t             entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  assign full    = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign valid   = (cnt_r != '0);
  assign pop_req = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_req;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[src/pccx_back.sv]
// ----------------------------------------------------------------------------
// Crossover engine
// Loads the parents into RAM while checking their tails, walks the crossover
// cycles via the position-of-gene table; emits child (first parent on error).
// ----------------------------------------------------------------------------
module pccx_back import pccx_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_valid,
  output logic    q_pop,
  input  req_t    q_req,
  output logic    out_valid,
  input  logic    out_stall,
  output gene_t   out_child_gene,
  output logic    out_last_gene,
  output status_t out_status
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_CHECK,
    S_SCAN,
    S_FETCH,
    S_LINK,
    S_EMIT
  } state_t;

  state_t    state_r, state_nxt;
  count_t    n_r, n_nxt;
  gene_t     head_r, head_nxt;
  status_t   err_r, err_nxt;
  logic      dup_r, dup_nxt;
  mark_vec_t present_r, present_nxt;
  mark_vec_t p2seen_r, p2seen_nxt;
  mark_vec_t visited_r, visited_nxt;
  logic      tfp_r, tfp_nxt;
  count_t    s_r, s_nxt;
  gene_t     cur_r, cur_nxt;
  count_t    e_r, e_nxt;
  logic      rd_v_r, rd_v_nxt;
  gene_t     rd_idx_r, rd_idx_nxt;
  logic      rd_last_r, rd_last_nxt;
  logic      out_valid_r, out_valid_nxt;
  gene_t     out_gene_r, out_gene_nxt;
  logic      out_last_r, out_last_nxt;
  status_t   out_status_r, out_status_nxt;

  logic  load, ld_wr, tail_wr;
  logic  walk_start, link_go, emit_more, emit_issue, adv;
  gene_t s_idx, e_idx, walk_addr;
  gene_t fp_rdata, sp_rdata, pog_rdata, child_rdata;
  logic  fp_re, sp_re, pog_re, child_we, child_re;
  gene_t fp_raddr;

  assign s_idx      = s_r[GENE_W-1:0];
  assign e_idx      = e_r[GENE_W-1:0];
  assign load       = (state_r == S_LOAD) && q_valid;
  assign q_pop      = load;
  assign ld_wr      = load && !q_req.drop;
  assign tail_wr    = ld_wr && (q_req.pos != '0);
  assign walk_start = (state_r == S_SCAN) && (s_r < n_r) && !visited_r[s_idx];
  assign link_go    = (state_r == S_LINK) && (pog_rdata != s_idx);
  assign walk_addr  = (state_r == S_SCAN) ? s_idx : pog_rdata;
  assign adv        = rd_v_r && (!out_valid_r || !out_stall);
  assign emit_more  = (e_r < n_r);
  assign emit_issue = (state_r == S_EMIT) && emit_more && (!rd_v_r || adv);
  assign fp_re      = walk_start || link_go || (emit_issue && (err_r != ST_OK));
  assign fp_raddr   = (state_r == S_EMIT) ? e_idx : walk_addr;
  assign sp_re      = walk_start || link_go;
  assign pog_re     = (state_r == S_FETCH);
  assign child_we   = (state_r == S_FETCH);
  assign child_re   = emit_issue && (err_r == ST_OK);

  pccx_ram #(.WIDTH(GENE_W), .DEPTH(STORE_DEPTH)) u_fp_ram (
    .clk(clk), .we(ld_wr), .waddr(q_req.pos), .wdata(q_req.first_gene),
    .re(fp_re), .raddr(fp_raddr), .rdata(fp_rdata)
  );

  pccx_ram #(.WIDTH(GENE_W), .DEPTH(STORE_DEPTH)) u_sp_ram (
    .clk(clk), .we(ld_wr), .waddr(q_req.pos), .wdata(q_req.second_gene),
    .re(sp_re), .raddr(walk_addr), .rdata(sp_rdata)
  );

  pccx_ram #(.WIDTH(GENE_W), .DEPTH(STORE_DEPTH)) u_pog_ram (
    .clk(clk), .we(tail_wr), .waddr(q_req.first_gene), .wdata(q_req.pos),
    .re(pog_re), .raddr(sp_rdata), .rdata(pog_rdata)
  );

  pccx_ram #(.WIDTH(GENE_W), .DEPTH(STORE_DEPTH)) u_child_ram (
    .clk(clk), .we(child_we), .waddr(cur_r), .wdata(tfp_r ? fp_rdata : sp_rdata),
    .re(child_re), .raddr(e_idx), .rdata(child_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    head_nxt       = head_r;
    err_nxt        = err_r;
    dup_nxt        = dup_r;
    present_nxt    = present_r;
    p2seen_nxt     = p2seen_r;
    visited_nxt    = visited_r;
    tfp_nxt        = tfp_r;
    s_nxt          = s_r;
    cur_nxt        = cur_r;
    e_nxt          = e_r;
    rd_v_nxt       = rd_v_r;
    rd_idx_nxt     = rd_idx_r;
    rd_last_nxt    = rd_last_r;
    out_valid_nxt  = out_valid_r;
    out_gene_nxt   = out_gene_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;

    case (state_r)
      S_LOAD: begin
        if (load) begin
          if (q_req.first_item) begin
            head_nxt = q_req.head;
          end
          if (q_req.drop) begin
            err_nxt = ST_OVERFLOW;
          end else begin
            n_nxt = n_r + 1'b1;
          end
          if (tail_wr) begin
            dup_nxt = dup_r || present_r[q_req.first_gene] || p2seen_r[q_req.second_gene];
            present_nxt[q_req.first_gene] = 1'b1;
            p2seen_nxt[q_req.second_gene] = 1'b1;
          end
          if (q_req.last_item) begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        e_nxt = '0;
        if (err_r != ST_OK) begin
          state_nxt = S_EMIT;
        end else if (dup_r || (present_r != p2seen_r)) begin
          err_nxt   = ST_MISMATCH;
          state_nxt = S_EMIT;
        end else begin
          s_nxt     = COUNT_W'(1);
          tfp_nxt   = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (s_r >= n_r) begin
          state_nxt = S_EMIT;
        end else if (visited_r[s_idx]) begin
          s_nxt = s_r + 1'b1;
        end else begin
          cur_nxt              = s_idx;
          visited_nxt[s_idx]   = 1'b1;
          state_nxt            = S_FETCH;
        end
      end
      S_FETCH: begin
        state_nxt = S_LINK;
      end
      S_LINK: begin
        if (link_go) begin
          cur_nxt                = pog_rdata;
          visited_nxt[pog_rdata] = 1'b1;
          state_nxt              = S_FETCH;
        end else begin
          tfp_nxt   = !tfp_r;
          s_nxt     = s_r + 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_EMIT: begin
        if (emit_issue) begin
          e_nxt       = e_r + 1'b1;
          rd_idx_nxt  = e_idx;
          rd_last_nxt = ((e_r + 1'b1) == n_r);
        end
        if (!emit_more && !rd_v_r) begin
          n_nxt       = '0;
          err_nxt     = ST_OK;
          dup_nxt     = 1'b0;
          present_nxt = '0;
          p2seen_nxt  = '0;
          visited_nxt = '0;
          tfp_nxt     = 1'b1;
          state_nxt   = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase

    if (emit_issue) begin
      rd_v_nxt = 1'b1;
    end else if (adv) begin
      rd_v_nxt = 1'b0;
    end

    if (adv) begin
      out_valid_nxt  = 1'b1;
      out_last_nxt   = rd_last_r;
      out_status_nxt = err_r;
      if (err_r != ST_OK) begin
        out_gene_nxt = fp_rdata;
      end else if (rd_idx_r == '0) begin
        out_gene_nxt = head_r;
      end else begin
        out_gene_nxt = child_rdata;
      end
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    rd_idx_r     <= rd_idx_nxt;
    rd_last_r    <= rd_last_nxt;
    out_gene_r   <= out_gene_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
    if (!rst_n) begin
      state_r     <= S_LOAD;
      n_r         <= '0;
      head_r      <= '0;
      err_r       <= ST_OK;
      dup_r       <= 1'b0;
      present_r   <= '0;
      p2seen_r    <= '0;
      visited_r   <= '0;
      tfp_r       <= 1'b1;
      s_r         <= '0;
      e_r         <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      head_r      <= head_nxt;
      err_r       <= err_nxt;
      dup_r       <= dup_nxt;
      present_r   <= present_nxt;
      p2seen_r    <= p2seen_nxt;
      visited_r   <= visited_nxt;
      tfp_r       <= tfp_nxt;
      s_r         <= s_nxt;
      e_r         <= e_nxt;
      rd_v_r      <= rd_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_child_gene = out_gene_r;
  assign out_last_gene  = out_last_r;
  assign out_status     = out_status_r;

endmodule

[src/permutation_cycle_crossover_core.sv]
// ----------------------------------------------------------------------------
// Permutation cycle crossover core
// Builds a child permutation from two parents by cycle crossover, keeping a
// fixed head city, and reports whether the parents could be crossed.
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_stall   parent genes, head city, last
//   out_     output     out_valid / out_stall child gene, last gene, status
//
// Each request is loaded from the queue. After the last request of a set the
// engine checks the tails, walks the crossover cycles over the tail positions,
// and then streams out the child genes. Each cycle step goes through the
// registered read of the parent and position-of-gene RAMs.
// Reset is synchronous and active low; no memory clearing pass is needed.
// A stalled output holds its request while up to four input requests queue.
// ----------------------------------------------------------------------------
module permutation_cycle_crossover_core import pccx_pkg::*; #(
  parameter int CITY_LIMIT = CITY_LIMIT_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  gene_t   in_first_parent_gene,
  input  gene_t   in_second_parent_gene,
  input  gene_t   in_head_city,
  input  logic    in_last_item,
  output logic    out_valid,
  input  logic    out_stall,
  output gene_t   out_child_gene,
  output logic    out_last_gene,
  output status_t out_status
);

  logic q_full, q_push, q_valid, q_pop;
  req_t push_req, pop_req;

  pccx_front #(.CITY_LIMIT(CITY_LIMIT)) u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_first_parent_gene (in_first_parent_gene),
    .in_second_parent_gene(in_second_parent_gene),
    .in_head_city         (in_head_city),
    .in_last_item         (in_last_item),
    .q_full               (q_full),
    .q_push               (q_push),
    .q_req                (push_req)
  );

  pccx_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_req(push_req),
    .full    (q_full),
    .valid   (q_valid),
    .pop     (q_pop),
    .pop_req (pop_req)
  );

  pccx_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_req         (pop_req),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_child_gene(out_child_gene),
    .out_last_gene (out_last_gene),
    .out_status    (out_status)
  );

endmodule

[src/pccx_checker.sv]
// ----------------------------------------------------------------------------
// Cycle crossover port checker
// Watches the core's ports for output handshake, status and reset behavior.
// ----------------------------------------------------------------------------
module pccx_checker import pccx_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  input logic    out_valid,
  input logic    out_stall,
  input gene_t   out_child_gene,
  input logic    out_last_gene,
  input status_t out_status
);

  logic    mid_r;
  logic    mid_nxt;
  status_t status_r;
  status_t status_nxt;
  logic    out_take;

  assign out_take = out_valid && !out_stall;

  always_comb begin
    mid_nxt    = mid_r;
    status_nxt = status_r;
    if (out_take) begin
      mid_nxt    = !out_last_gene;
      status_nxt = out_status;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    if (!rst_n) begin
      mid_r <= 1'b0;
    end else begin
      mid_r <= mid_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("Output request dropped while stalled.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_child_gene) && $stable(out_last_gene)
                               && $stable(out_status))
    else $error("Output request changed while stalled.");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK) || (out_status == ST_OVERFLOW)
                  || (out_status == ST_MISMATCH))
    else $error("Output status carries an unused code.");

  a_status_uniform: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mid_r |-> out_status == status_r)
    else $error("Status changed within one child.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Output valid right after reset.");

endmodule

bind permutation_cycle_crossover_core pccx_checker u_checker (.*);

[bench/tb_permutation_cycle_crossover_core.sv]
// ----------------------------------------------------------------------------
// Cycle crossover core testbench
// Feeds parent pairs one position per request and checks every child gene,
// last marker and status against a scoreboard that crosses the same parents.
// The stimulus covers single positions, full and overflowing sets, parents
// whose tails differ, and random crossable parents under sender idling and
// receiver stalls.
// ----------------------------------------------------------------------------
import pccx_pkg::*;

class crossover_scoreboard;
  gene_t       first_genes[STORE_DEPTH];
  gene_t       second_genes[STORE_DEPTH];
  gene_t       pos_of[STORE_DEPTH];
  gene_t       child[STORE_DEPTH];
  int unsigned loaded;
  gene_t       head;
  status_t     set_status;
  gene_t       due_gene[$];
  logic        due_last[$];
  status_t     due_status[$];
  int unsigned errors;

  function new();
    loaded = 0;
    head = '0;
    set_status = ST_OK;
    errors = 0;
  endfunction

  function int unsigned pending();
    return due_gene.size();
  endfunction

  function bit tails_agree(int unsigned n);
    bit in_first[STORE_DEPTH];
    bit in_second[STORE_DEPTH];
    int unsigned i;
    for (i = 0; i < STORE_DEPTH; i++) begin
      in_first[i] = 0;
      in_second[i] = 0;
    end
    for (i = 1; i < n; i++) begin
      if (in_first[first_genes[i]]) return 0;
      in_first[first_genes[i]] = 1;
      pos_of[first_genes[i]] = gene_t'(i);
    end
    for (i = 1; i < n; i++) begin
      if (!in_first[second_genes[i]] || in_second[second_genes[i]]) return 0;
      in_second[second_genes[i]] = 1;
    end
    return 1;
  endfunction

  function void cross_tails(int unsigned n);
    bit walked[STORE_DEPTH];
    bit from_first;
    int unsigned s;
    int unsigned cur;
    int unsigned steps;
    for (s = 0; s < STORE_DEPTH; s++) walked[s] = 0;
    child[0] = head;
    from_first = 1;
    for (s = 1; s < n; s++) begin
      if (!walked[s]) begin
        cur = s;
        steps = 0;
        do begin
          child[cur] = from_first ? first_genes[cur] : second_genes[cur];
          walked[cur] = 1;
          cur = pos_of[second_genes[cur]];
          steps++;
        end while (cur != s && steps < n);
        from_first = !from_first;
      end
    end
  endfunction

  function void note_request(gene_t first_gene, gene_t second_gene, gene_t head_city,
                             logic is_last);
    int unsigned n;
    int unsigned i;
    if (loaded == 0) head = head_city;
    if (loaded < CITY_LIMIT_DEF) begin
      first_genes[loaded] = first_gene;
      second_genes[loaded] = second_gene;
      loaded++;
    end else begin
      set_status = ST_OVERFLOW;
    end
    if (!is_last) return;
    n = loaded;
    if (set_status == ST_OK && !tails_agree(n)) set_status = ST_MISMATCH;
    if (set_status == ST_OK) begin
      cross_tails(n);
    end else begin
      for (i = 0; i < n; i++) child[i] = first_genes[i];
    end
    for (i = 0; i < n; i++) begin
      due_gene.insert(due_gene.size(), child[i]);
      due_last.insert(due_last.size(), i + 1 == n);
      due_status.insert(due_status.size(), set_status);
    end
    loaded = 0;
    set_status = ST_OK;
  endfunction

  function void check_child(gene_t gene, logic is_last, status_t status);
    gene_t   want_gene;
    logic    want_last;
    status_t want_status;
    if (due_gene.size() == 0) begin
      $error("child gene %0d arrived with no gene expected", gene);
      errors++;
      return;
    end
    want_gene = due_gene.pop_front();
    want_last = due_last.pop_front();
    want_status = due_status.pop_front();
    if (gene !== want_gene) begin
      $error("out_child_gene expected %0d actual %0d", want_gene, gene);
      errors++;
    end
    if (is_last !== want_last) begin
      $error("out_last_gene expected %0d actual %0d", want_last, is_last);
      errors++;
    end
    if (status !== want_status) begin
      $error("out_status expected %0d actual %0d", want_status, status);
      errors++;
    end
  endfunction
endclass

module tb_permutation_cycle_crossover_core;

  localparam int unsigned RANDOM_TARGET = 460;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned DRAIN_CYCLES  = 300;
  localparam int unsigned PLAN_DEPTH    = 68;

  typedef enum {
    PLAN_CROSSABLE,
    PLAN_FIRST_REPEAT,
    PLAN_SECOND_REPEAT,
    PLAN_SECOND_FOREIGN,
    PLAN_NOISE
  } plan_kind_t;

  logic    clk;
  logic    rst_n;
  logic    in_valid;
  logic    in_stall;
  gene_t   in_first_parent_gene;
  gene_t   in_second_parent_gene;
  gene_t   in_head_city;
  logic    in_last_item;
  logic    out_valid;
  logic    out_stall;
  gene_t   out_child_gene;
  logic    out_last_gene;
  status_t out_status;

  crossover_scoreboard sb;
  int unsigned         cycle_count;
  int unsigned         items_sent;
  int unsigned         send_idle_pct;
  int unsigned         stall_pct;
  gene_t               plan_first[PLAN_DEPTH];
  gene_t               plan_second[PLAN_DEPTH];
  gene_t               pool[STORE_DEPTH];

  permutation_cycle_crossover_core DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_first_parent_gene  (in_first_parent_gene),
    .in_second_parent_gene (in_second_parent_gene),
    .in_head_city          (in_head_city),
    .in_last_item          (in_last_item),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_child_gene        (out_child_gene),
    .out_last_gene         (out_last_gene),
    .out_status            (out_status)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    out_stall = 0;
    forever begin
      @(negedge clk);
      out_stall = (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_child(out_child_gene, out_last_gene, out_status);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic offer_request(input gene_t first_gene, input gene_t second_gene,
                               input gene_t head_city, input logic is_last);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_first_parent_gene = first_gene;
    in_second_parent_gene = second_gene;
    in_head_city = head_city;
    in_last_item = is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(first_gene, second_gene, head_city, is_last);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_plan(input int unsigned n, input gene_t head_city);
    int unsigned i;
    for (i = 0; i < n; i++) begin
      offer_request(plan_first[i], plan_second[i],
                    (i == 0) ? head_city : gene_t'($urandom_range(63)), i + 1 == n);
    end
  endtask

  task automatic plan_at(input int unsigned i, input gene_t first_gene,
                         input gene_t second_gene);
    plan_first[i] = first_gene;
    plan_second[i] = second_gene;
  endtask

  task automatic build_plan(input int unsigned n, input plan_kind_t kind);
    int unsigned i;
    int unsigned j;
    int unsigned k;
    gene_t       swap;
    for (i = 0; i < STORE_DEPTH; i++) pool[i] = gene_t'(i);
    for (i = STORE_DEPTH - 1; i > 0; i--) begin
      j = $urandom_range(i);
      swap = pool[i];
      pool[i] = pool[j];
      pool[j] = swap;
    end
    plan_first[0] = gene_t'($urandom_range(63));
    plan_second[0] = gene_t'($urandom_range(63));
    for (i = 1; i < n; i++) begin
      plan_first[i] = pool[i - 1];
      plan_second[i] = pool[i - 1];
    end
    if ($urandom_range(9) != 0) begin
      for (i = n - 1; i >= 2; i--) begin
        j = $urandom_range(1, i);
        swap = plan_second[i];
        plan_second[i] = plan_second[j];
        plan_second[j] = swap;
      end
    end
    if ((kind == PLAN_FIRST_REPEAT || kind == PLAN_SECOND_REPEAT) && n < 3) kind = PLAN_NOISE;
    if (kind == PLAN_SECOND_FOREIGN && n < 2) kind = PLAN_NOISE;
    i = $urandom_range(1, n - 1);
    j = (n >= 3) ? $urandom_range(1, n - 2) : 1;
    if (j >= i) j++;
    case (kind)
      PLAN_FIRST_REPEAT: begin
        plan_first[j] = plan_first[i];
      end
      PLAN_SECOND_REPEAT: begin
        plan_second[j] = plan_second[i];
      end
      PLAN_SECOND_FOREIGN: begin
        plan_second[i] = pool[n - 1];
      end
      PLAN_NOISE: begin
        for (k = 0; k < n; k++) begin
          plan_first[k] = gene_t'($urandom_range(63));
          plan_second[k] = gene_t'($urandom_range(63));
        end
      end
      default: begin
      end
    endcase
  endtask

  initial begin
    int unsigned pick;
    int unsigned n;
    int unsigned extra;
    int unsigned i;
    plan_kind_t  kind;

    sb = new();
    cycle_count = 0;
    items_sent = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    rst_n = 0;
    in_valid = 0;
    in_first_parent_gene = '0;
    in_second_parent_gene = '0;
    in_head_city = '0;
    in_last_item = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // A single position yields the head city alone.
    plan_at(0, 63, 63);
    send_plan(1, 63);
    plan_at(0, 0, 0);
    send_plan(1, 0);
    plan_at(0, 0, 63);
    plan_at(1, 63, 63);
    send_plan(2, 0);
    // Two cycles: positions one and two, then position three on its own.
    plan_at(0, 63, 0);
    plan_at(1, 0, 63);
    plan_at(2, 63, 0);
    plan_at(3, 5, 5);
    send_plan(4, 63);
    plan_at(0, 1, 2);
    plan_at(1, 7, 7);
    plan_at(2, 7, 9);
    send_plan(3, 12);
    plan_at(0, 0, 0);
    plan_at(1, 4, 4);
    plan_at(2, 5, 4);
    send_plan(3, 33);
    plan_at(0, 0, 0);
    plan_at(1, 4, 4);
    plan_at(2, 5, 6);
    send_plan(3, 21);
    // The head city also appears in the tails.
    plan_at(0, 9, 9);
    plan_at(1, 9, 11);
    plan_at(2, 10, 9);
    plan_at(3, 11, 10);
    send_plan(4, 9);

    while (items_sent < RANDOM_TARGET) begin
      if (items_sent >= 3 * RANDOM_TARGET / 4) begin
        send_idle_pct = 22;
        stall_pct = 22;
      end else if (items_sent >= RANDOM_TARGET / 2) begin
        send_idle_pct = 0;
        stall_pct = 54;
      end else if (items_sent >= RANDOM_TARGET / 4) begin
        send_idle_pct = 54;
        stall_pct = 0;
      end
      pick = $urandom_range(99);
      kind = ($urandom_range(99) < 70) ? PLAN_CROSSABLE : plan_kind_t'($urandom_range(1, 4));
      extra = 0;
      if (pick < 6) begin
        n = STORE_DEPTH;
        if ($urandom_range(2) == 0) extra = $urandom_range(1, 3);
      end else begin
        n = $urandom_range(1, 12);
      end
      build_plan(n, kind);
      for (i = n; i < n + extra; i++) begin
        plan_first[i] = gene_t'($urandom_range(63));
        plan_second[i] = gene_t'($urandom_range(63));
      end
      send_plan(n + extra, gene_t'($urandom_range(63)));
    end

    in_valid = 0;
    in_last_item = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
